@@ rtl/ovc_pkg.sv @@
`default_nettype none

package ovc_pkg;

    // Key codes (ASCII)
    localparam logic [7:0] KEY_START = 8'h73;  // 's'
    localparam logic [7:0] KEY_HALT  = 8'h68;  // 'h'
    localparam logic [7:0] KEY_ZERO  = 8'h30;  // '0'
    localparam logic [7:0] KEY_NINE  = 8'h39;  // '9'

    // Reset values
    localparam logic [15:0] TIME_RESET = 16'd90;
    localparam logic [7:0]  STEP_RESET = 8'd3;
    localparam logic [7:0]  TICK_MAX   = 8'hFF;

    // mm:ss step down: xx00 -> (xx-1)59 is a drop of 41
    localparam logic [15:0] MINUTE_BORROW = 16'd41;

    // floor(t / 100) = (t * DIV100_MUL) >> DIV100_SHIFT for any 16-bit t
    localparam logic [16:0] DIV100_MUL   = 17'd83887;
    localparam int          DIV100_SHIFT = 23;

    typedef enum logic {
        MODE_IDLE = 1'b0,
        MODE_HEAT = 1'b1
    } ovc_mode_t;

    // One scheduler pass worth of inputs
    typedef struct packed {
        logic       tick;
        logic [7:0] key_code;
        logic       door_closed;
        logic       weight_present;
    } ovc_item_t;

    // Controller state; everything but tick_count is shown on the result port
    typedef struct packed {
        ovc_mode_t   mode;
        logic [15:0] time_left;
        logic [7:0]  tick_count;
        logic        end_flag;
        logic        drive_state;
    } ovc_state_t;

endpackage

`default_nettype wire

@@ rtl/ovc_time_unit.sv @@
`default_nettype none

module ovc_time_unit (
    input  wire logic [15:0] time_in,
    input  wire logic [3:0]  digit,
    output logic [15:0]      time_shift,
    output logic [15:0]      time_dec
);
    import ovc_pkg::*;

    logic [32:0] div_prod;
    logic [9:0]  quot;
    logic [16:0] quot_x100;
    logic        rem_zero;

    // Digit entry: time * 10 + d, wrapping at 16 bits
    assign time_shift = (time_in << 3) + (time_in << 1) + {12'd0, digit};

    // Seconds field zero test via reciprocal multiply, then q*100 by shifts
    assign div_prod  = {17'd0, time_in} * {16'd0, DIV100_MUL};
    assign quot      = div_prod[DIV100_SHIFT +: 10];
    assign quot_x100 = ({7'd0, quot} << 6) + ({7'd0, quot} << 5) + ({7'd0, quot} << 2);
    assign rem_zero  = (quot_x100[15:0] == time_in);

    // mm:ss decrement; caller only uses it for nonzero time
    assign time_dec = rem_zero ? (time_in - MINUTE_BORROW) : (time_in - 16'd1);

endmodule

`default_nettype wire

@@ rtl/ovc_pass.sv @@
`default_nettype none

module ovc_pass (
    input  wire ovc_pkg::ovc_state_t state_in,
    input  wire ovc_pkg::ovc_item_t  item,
    input  wire logic [7:0]          ticks_per_step,
    output ovc_pkg::ovc_state_t      state_out
);
    import ovc_pkg::*;

    logic [15:0] time_shift;
    logic [15:0] time_dec;
    logic [7:0]  tick_cnt;
    logic        is_digit;
    logic        interlock_ok;

    ovc_time_unit u_time (
        .time_in    (state_in.time_left),
        .digit      (item.key_code[3:0]),
        .time_shift (time_shift),
        .time_dec   (time_dec)
    );

    assign is_digit     = (item.key_code >= KEY_ZERO) && (item.key_code <= KEY_NINE);
    assign interlock_ok = item.door_closed && item.weight_present;

    // Saturating tick count
    assign tick_cnt = (item.tick && (state_in.tick_count != TICK_MAX)) ?
                      state_in.tick_count + 8'd1 : state_in.tick_count;

    // One pass of the controller
    always_comb begin
        state_out            = state_in;
        state_out.tick_count = tick_cnt;

        if (tick_cnt != 8'd0) begin
            if (state_in.mode == MODE_IDLE) begin
                if (item.key_code == KEY_START) begin
                    if (interlock_ok && (state_in.time_left != 16'd0)) begin
                        state_out.mode        = MODE_HEAT;
                        state_out.end_flag    = 1'b0;
                        state_out.drive_state = 1'b1;
                    end
                end else if (item.key_code == KEY_HALT) begin
                    state_out.end_flag  = 1'b0;
                    state_out.time_left = 16'd0;
                end else if (is_digit) begin
                    state_out.end_flag  = 1'b0;
                    state_out.time_left = time_shift;
                end
            end else begin
                // countdown step
                if (tick_cnt >= ticks_per_step) begin
                    state_out.tick_count = 8'd0;
                    if (state_in.time_left == 16'd0) begin
                        state_out.drive_state = 1'b0;
                        state_out.end_flag    = 1'b1;
                    end else begin
                        state_out.time_left = time_dec;
                    end
                end
                if (item.key_code == KEY_HALT) begin
                    state_out.mode        = MODE_IDLE;
                    state_out.drive_state = 1'b0;
                end
            end
        end

        // Door or load interlock drops back to idle
        if ((state_out.mode == MODE_HEAT) && !interlock_ok) begin
            state_out.mode        = MODE_IDLE;
            state_out.drive_state = 1'b0;
        end
    end

endmodule

`default_nettype wire

@@ rtl/oven_countdown_controller.sv @@
// s_ beats go through the input register, then the state register, to m_.
// Throughput: one beat per cycle; s_ready stays high while the result register
// is empty or being drained, so the pass logic never waits on itself.
// Reset (aresetn low, synchronous): idle, time 90, tick count 0, end flag and
// drive off, ticks_per_step 3, both channels empty.
`default_nettype none

module oven_countdown_controller (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    // input channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_tick,
    input  wire logic [7:0]  s_key_code,
    input  wire logic        s_door_closed,
    input  wire logic        s_weight_present,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_drive_on,
    output logic             m_heating,
    output logic [15:0]      m_remaining_time,
    output logic             m_show_end
);
    import ovc_pkg::*;

    logic       in_valid_reg;
    ovc_item_t  in_item_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    ovc_state_t state_reg;
    ovc_state_t state_next;
    logic [7:0] tps_reg;
    logic       pass_fire;

    // A pass runs when an item waits and the result register is free
    assign pass_fire = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || pass_fire;

    ovc_pass u_pass (
        .state_in       (state_reg),
        .item           (in_item_reg),
        .ticks_per_step (tps_reg),
        .state_out      (state_next)
    );

    // Config register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tps_reg <= STEP_RESET;
        end else if (cfg_wr_en) begin
            tps_reg <= cfg_wr_data;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= '{tick:           s_tick,
                             key_code:       s_key_code,
                             door_closed:    s_door_closed,
                             weight_present: s_weight_present};
        end
    end

    // State doubles as the result payload: it only moves on a pass, which
    // only happens once the previous result beat is gone
    always_comb begin
        out_valid_next = out_valid_reg;
        if (pass_fire) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            state_reg     <= '{mode:        MODE_IDLE,
                               time_left:   TIME_RESET,
                               tick_count:  8'd0,
                               end_flag:    1'b0,
                               drive_state: 1'b0};
        end else begin
            out_valid_reg <= out_valid_next;
            if (pass_fire) begin
                state_reg <= state_next;
            end
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_drive_on       = state_reg.drive_state;
    assign m_heating        = (state_reg.mode == MODE_HEAT);
    assign m_remaining_time = state_reg.time_left;
    assign m_show_end       = state_reg.end_flag;

endmodule

`default_nettype wire

@@ rtl/ovc_checker.sv @@
`default_nettype none

module ovc_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic        m_drive_on,
    input wire logic        m_heating,
    input wire logic [15:0] m_remaining_time,
    input wire logic        m_show_end
);

    // A stalled result beat holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_remaining_time) &&
        $stable(m_heating) && $stable(m_drive_on) && $stable(m_show_end))
        else $error("result beat changed while stalled");

    // Drive is never on outside heating
    a_drive_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        m_drive_on |-> m_heating)
        else $error("drive on while idle");

    // End of cook while heating means the drive is off
    a_end_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_show_end && m_heating |-> !m_drive_on)
        else $error("drive on with end flag set");

    // Reset empties the result channel and leaves the oven idle
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !m_heating && !m_drive_on && !m_show_end)
        else $error("bad state after reset");

endmodule

bind oven_countdown_controller ovc_checker u_ovc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_drive_on       (m_drive_on),
    .m_heating        (m_heating),
    .m_remaining_time (m_remaining_time),
    .m_show_end       (m_show_end)
);

`default_nettype wire

@@ sim/ovc_result_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the oven controller, keeps its own copy of the
// controller state and step register, and compares each result beat with the
// oldest predicted one.
module ovc_result_checker
    import ovc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [7:0]  cfg_wr_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic        s_tick,
    input  wire logic [7:0]  s_key_code,
    input  wire logic        s_door_closed,
    input  wire logic        s_weight_present,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic        m_drive_on,
    input  wire logic        m_heating,
    input  wire logic [15:0] m_remaining_time,
    input  wire logic        m_show_end,
    output int               error_count,
    output int               results_due
);

    typedef struct packed {
        logic        drive_on;
        logic        heating;
        logic [15:0] remaining_time;
        logic        show_end;
    } oven_display_t;

    ovc_state_t    ctrl;
    logic [7:0]    step_count;
    oven_display_t display_q[$];
    int            mismatches = 0;

    // One scheduler pass: tick count, key handling by mode, then the interlock
    task automatic predict_pass(input ovc_item_t pass, output oven_display_t res);
        logic door_ok;
        door_ok = pass.door_closed && pass.weight_present;

        if (pass.tick && ctrl.tick_count != TICK_MAX)
            ctrl.tick_count = ctrl.tick_count + 8'd1;

        if (ctrl.tick_count != 8'd0) begin
            if (ctrl.mode == MODE_IDLE) begin
                if (pass.key_code == KEY_START) begin
                    if (door_ok && ctrl.time_left != 16'd0) begin
                        ctrl.mode        = MODE_HEAT;
                        ctrl.end_flag    = 1'b0;
                        ctrl.drive_state = 1'b1;
                    end
                end else if (pass.key_code == KEY_HALT) begin
                    ctrl.end_flag  = 1'b0;
                    ctrl.time_left = 16'd0;
                end else if (pass.key_code >= KEY_ZERO && pass.key_code <= KEY_NINE) begin
                    // shift the digit in, wrapping at 16 bits
                    ctrl.end_flag  = 1'b0;
                    ctrl.time_left = 16'(ctrl.time_left * 16'd10
                                         + 16'(pass.key_code - KEY_ZERO));
                end
            end else begin
                if (ctrl.tick_count >= step_count) begin
                    ctrl.tick_count = 8'd0;
                    if (ctrl.time_left == 16'd0) begin
                        ctrl.drive_state = 1'b0;
                        ctrl.end_flag    = 1'b1;
                    end else if (ctrl.time_left % 16'd100 != 16'd0) begin
                        ctrl.time_left = ctrl.time_left - 16'd1;
                    end else begin
                        // mm:00 borrows a minute: xx00 -> (xx-1)59
                        ctrl.time_left = ctrl.time_left - MINUTE_BORROW;
                    end
                end
                if (pass.key_code == KEY_HALT) begin
                    ctrl.mode        = MODE_IDLE;
                    ctrl.drive_state = 1'b0;
                end
            end
        end

        // door open or no load drops out of heating
        if (ctrl.mode == MODE_HEAT && !door_ok) begin
            ctrl.mode        = MODE_IDLE;
            ctrl.drive_state = 1'b0;
        end

        res.drive_on       = ctrl.drive_state;
        res.heating        = ctrl.mode;
        res.remaining_time = ctrl.time_left;
        res.show_end       = ctrl.end_flag;
    endtask

    always @(posedge aclk) begin
        oven_display_t want;
        oven_display_t got;
        ovc_item_t     pass;
        if (!aresetn) begin
            ctrl.mode        = MODE_IDLE;
            ctrl.time_left   = TIME_RESET;
            ctrl.tick_count  = 8'd0;
            ctrl.end_flag    = 1'b0;
            ctrl.drive_state = 1'b0;
            step_count       = STEP_RESET;
            display_q.delete();
        end else begin
            if (cfg_wr_en)
                step_count = cfg_wr_data;

            // result side first so a fresh prediction never masks a stray beat
            if (m_valid && m_ready) begin
                got = '{m_drive_on, m_heating, m_remaining_time, m_show_end};
                if (display_q.size() == 0) begin
                    $error("result beat with nothing expected (remaining_time %0d)",
                           m_remaining_time);
                    mismatches++;
                end else begin
                    want = display_q.pop_front();
                    if (got.drive_on !== want.drive_on) begin
                        $error("drive_on: expected %0d, got %0d", want.drive_on, got.drive_on);
                        mismatches++;
                    end
                    if (got.heating !== want.heating) begin
                        $error("heating: expected %0d, got %0d", want.heating, got.heating);
                        mismatches++;
                    end
                    if (got.remaining_time !== want.remaining_time) begin
                        $error("remaining_time: expected %0d, got %0d",
                               want.remaining_time, got.remaining_time);
                        mismatches++;
                    end
                    if (got.show_end !== want.show_end) begin
                        $error("show_end: expected %0d, got %0d", want.show_end, got.show_end);
                        mismatches++;
                    end
                end
            end

            if (s_valid && s_ready) begin
                pass = '{s_tick, s_key_code, s_door_closed, s_weight_present};
                predict_pass(pass, want);
                display_q.push_back(want);
            end
        end
        error_count <= mismatches;
        results_due <= display_q.size();
    end

endmodule

@@ sim/tb_oven_countdown_controller.sv @@
`timescale 1ns / 1ps

module tb_oven_countdown_controller;
    import ovc_pkg::*;

    localparam int CYCLE_LIMIT = 500000;

    logic        aclk             = 1'b0;
    logic        aresetn          = 1'b0;
    logic        cfg_wr_en        = 1'b0;
    logic [7:0]  cfg_wr_data      = 8'd0;
    logic        s_valid          = 1'b0;
    logic        s_ready;
    logic        s_tick           = 1'b0;
    logic [7:0]  s_key_code       = 8'd0;
    logic        s_door_closed    = 1'b0;
    logic        s_weight_present = 1'b0;
    logic        m_valid;
    logic        m_ready          = 1'b0;
    logic        m_drive_on;
    logic        m_heating;
    logic [15:0] m_remaining_time;
    logic        m_show_end;

    int          error_count;
    int          results_due;
    int          passes_sent  = 0;
    int          cycle_count  = 0;
    int          ready_hold   = 0;
    bit          allow_idle   = 1'b1;
    logic [7:0]  step_count   = STEP_RESET;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    oven_countdown_controller u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_tick           (s_tick),
        .s_key_code       (s_key_code),
        .s_door_closed    (s_door_closed),
        .s_weight_present (s_weight_present),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive_on       (m_drive_on),
        .m_heating        (m_heating),
        .m_remaining_time (m_remaining_time),
        .m_show_end       (m_show_end)
    );

    ovc_result_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_tick           (s_tick),
        .s_key_code       (s_key_code),
        .s_door_closed    (s_door_closed),
        .s_weight_present (s_weight_present),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_drive_on       (m_drive_on),
        .m_heating        (m_heating),
        .m_remaining_time (m_remaining_time),
        .m_show_end       (m_show_end),
        .error_count      (error_count),
        .results_due      (results_due)
    );

    // Result side: stall m_ready in random bursts while idling is allowed
    always @(posedge aclk) begin
        if (ready_hold > 0) begin
            m_ready    <= 1'b0;
            ready_hold <= ready_hold - 1;
        end else if (allow_idle && $urandom_range(0, 5) == 0) begin
            m_ready    <= 1'b0;
            ready_hold <= $urandom_range(0, 8);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Drive one pass beat and wait for it to be taken
    task automatic send_pass(input logic tick, input logic [7:0] key,
                             input logic door, input logic weight);
        int gap;
        gap = 0;
        if (allow_idle && $urandom_range(0, 4) == 0)
            gap = $urandom_range(1, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid          <= 1'b1;
        s_tick           <= tick;
        s_key_code       <= key;
        s_door_closed    <= door;
        s_weight_present <= weight;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        passes_sent++;
    endtask

    // Sender holds off until every predicted result has come back
    task automatic drain_results;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic write_step_count(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        step_count  = value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic [7:0] random_key();
        case ($urandom_range(0, 5))
            0:       return KEY_START;
            1:       return KEY_HALT;
            2, 3:    return KEY_ZERO + 8'($urandom_range(0, 9));
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Clear, key in a short time, start, then let it count down with some noise
    task automatic cook_session;
        int         digits;
        int         heat_len;
        bit         slow_steps;
        logic       tick;
        logic [7:0] key;
        logic [7:0] digit;
        logic       door;
        logic       weight;

        slow_steps = (step_count > 8'd20);
        send_pass(1'b1, KEY_HALT, 1'b1, 1'b1);

        if (slow_steps)
            digits = 1;
        else if (step_count > 8'd3)
            digits = $urandom_range(1, 2);
        else
            digits = $urandom_range(1, 3);
        for (int d = 0; d < digits; d++) begin
            if (slow_steps)
                digit = 8'($urandom_range(1, 2));
            else if (d == 0 && digits == 3)
                digit = 8'd1;
            else
                digit = 8'($urandom_range(0, 9));
            send_pass(1'($urandom_range(0, 1)), KEY_ZERO + digit, 1'b1, 1'b1);
        end

        send_pass(1'($urandom_range(0, 1)), KEY_START, 1'b1, 1'b1);

        heat_len = slow_steps ? 320 : $urandom_range(1, 30) + 12 * int'(step_count);
        for (int i = 0; i < heat_len; i++) begin
            tick   = ($urandom_range(0, 9) < (slow_steps ? 9 : 7));
            key    = 8'h00;
            door   = 1'b1;
            weight = 1'b1;
            if (!slow_steps) begin
                case ($urandom_range(0, 59))
                    0:       key = KEY_HALT;
                    1, 2:    key = random_key();
                    default: ;
                endcase
                // occasional interlock glitch
                if ($urandom_range(0, 79) == 0) begin
                    door   = 1'($urandom_range(0, 1));
                    weight = 1'($urandom_range(0, 1));
                end
            end
            send_pass(tick, key, door, weight);
        end

        if ($urandom_range(0, 1))
            send_pass(1'($urandom_range(0, 1)), KEY_HALT, 1'b1, 1'b1);
    endtask

    task automatic noise_burst;
        repeat ($urandom_range(1, 20))
            send_pass(1'($urandom_range(0, 1)), random_key(),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endtask

    task automatic run_phase(input int quota);
        int stop_at;
        stop_at = passes_sent + quota;
        while (passes_sent < stop_at) begin
            if ($urandom_range(0, 9) < 7)
                cook_session();
            else
                noise_burst();
        end
    endtask

    initial begin
        logic [7:0] key;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: keys ignored until the first tick
        send_pass(1'b0, KEY_ZERO + 8'd5, 1'b1, 1'b1);
        send_pass(1'b0, KEY_START, 1'b1, 1'b1);
        send_pass(1'b1, 8'h00, 1'b1, 1'b1);
        send_pass(1'b0, 8'hFF, 1'b0, 1'b0);
        // time wraps past 16 bits
        repeat (5) send_pass(1'b0, KEY_NINE, 1'b1, 1'b1);
        send_pass(1'b1, KEY_HALT, 1'b1, 1'b1);
        // start refused at zero time, then with door open, then with no load
        send_pass(1'b0, KEY_START, 1'b1, 1'b1);
        send_pass(1'b0, KEY_ZERO + 8'd1, 1'b1, 1'b1);
        send_pass(1'b0, KEY_ZERO, 1'b1, 1'b1);
        send_pass(1'b0, KEY_ZERO, 1'b1, 1'b1);
        send_pass(1'b0, KEY_START, 1'b0, 1'b1);
        send_pass(1'b0, KEY_START, 1'b1, 1'b0);
        send_pass(1'b0, KEY_START, 1'b1, 1'b1);
        // 1:00 borrows to 0:59, then a plain step
        send_pass(1'b1, 8'h00, 1'b1, 1'b1);
        repeat (3) send_pass(1'b1, 8'h00, 1'b1, 1'b1);
        // halt while heating, restart, then the door opens
        send_pass(1'b1, KEY_HALT, 1'b1, 1'b1);
        send_pass(1'b0, KEY_START, 1'b1, 1'b1);
        send_pass(1'b0, 8'h00, 1'b0, 1'b1);

        // Long idle stretch so the tick count saturates
        repeat (270) begin
            key = random_key();
            if (key == KEY_START)
                key = 8'h00;
            send_pass(1'b1, key, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end

        run_phase(140);
        drain_results();
        write_step_count(8'd1);
        run_phase(140);
        drain_results();
        write_step_count(8'd0);
        run_phase(100);
        drain_results();
        write_step_count(8'd255);
        cook_session();
        drain_results();
        write_step_count(8'($urandom_range(2, 15)));
        run_phase(140);
        drain_results();

        // Last stretch at full rate on both sides
        allow_idle <= 1'b0;
        write_step_count(8'd2);
        run_phase(120);
        drain_results();
        repeat (4) @(posedge aclk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // Watchdog
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule
